// File: src/byte_stability_erasure_guess_top_defines.svh
// Assertion macros for the byte stability erasure guesser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BYTE_STABILITY_ERASURE_GUESS_TOP_DEFINES_SVH
`define BYTE_STABILITY_ERASURE_GUESS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every aclk edge outside reset.
`define BSEG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Trigger on one edge, consequence on the next.
`define BSEG_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);
`else
`define BSEG_ASSERT(name, prop, msg)
`define BSEG_ASSERT_NEXT(name, trig, cons, msg)
`endif

`endif

// File: src/bseg_pkg.sv
// Shared types and constants for the byte stability erasure guesser.
// No dependencies; imported by the top level.
`default_nettype none

package bseg_pkg;

    // default geometry
    localparam int FRAME_LEN_DEF = 256;
    localparam int HALVE_AT_DEF  = 512;

    // field widths
    localparam int MODE_W    = 2;
    localparam int POS_W     = 9;
    localparam int SYM_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int LEVEL_W   = 10;
    localparam int FCOUNT_W  = 10;
    localparam int CFG_IDX_W = 1;

    // stream packing
    localparam int S_TDATA_W = 32;  // position, symbol, zero fill
    localparam int M_TDATA_W = 24;  // out_byte, lowest_level, zero fill

    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_ALL_ONES = '1;

    // item kinds carried in s_tuser
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPL_THRESH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERA_THRESH  = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HALVE
    } state_t;

endpackage

`default_nettype wire

// File: src/byte_stability_erasure_guess_top.sv
// Byte stability erasure guesser, top level.
// Depends on bseg_pkg, bseg_ram and byte_stability_erasure_guess_top_defines.svh.
`default_nettype none

// Keeps, for every byte position of a repeating frame, the last byte seen and
// a saturating 9-bit change count, both in one synchronous RAM entry. Update
// transactions (tuser = update) write frame bytes; the first frame only primes
// the store, tlast closes a frame. Query transactions repair a symbol from the
// position's history and report an erasure flag on m_tuser; every transaction,
// of any kind, returns exactly one result carrying the current lowest change
// count above the erasure level. Each transaction is one RAM read followed by
// one read-modify-write; a transaction is taken in the same cycle the
// previous one retires, with a forwarding register covering a repeat of the
// same position, so the block sustains one transaction per cycle while the
// result side keeps up and no sweep runs (m_tvalid is registered). When
// the frame counter reaches HALVE_AT, the RAM is swept once to halve every
// count; s_tready stays low from the closing transaction until the sweep
// is over. The store has no reset sweep; a query of a position that no
// update has written returns unspecified data.
// Configuration writes must only happen while no transaction is in flight.
module byte_stability_erasure_guess_top #(
    parameter int FRAME_LEN = bseg_pkg::FRAME_LEN_DEF,
    parameter int HALVE_AT  = bseg_pkg::HALVE_AT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [bseg_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [bseg_pkg::LEVEL_W-1:0]   cfg_wdata,

    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bseg_pkg::S_TDATA_W-1:0] s_tdata,  // [8:0] position, [24:9] symbol
    input  wire logic [bseg_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
    input  wire logic                           s_tlast,  // frame_end

    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [bseg_pkg::M_TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [17:8] lowest_level
    output logic                                m_tuser   // erased
);

    import bseg_pkg::*;

    `include "byte_stability_erasure_guess_top_defines.svh"

    localparam int AW      = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int CW      = $clog2(FRAME_LEN + 1);
    localparam int ENTRY_W = BYTE_W + COUNT_W;

    localparam logic [POS_W:0]    POS_LIMIT   = (POS_W + 1)'(FRAME_LEN);
    localparam logic [CW-1:0]     SWEEP_LIMIT = CW'(FRAME_LEN);
    localparam logic [FCOUNT_W:0] HALVE_LIMIT = (FCOUNT_W + 1)'(HALVE_AT);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;

    // item under execution
    logic [MODE_W-1:0]    mode_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [SYM_W-1:0]     sym_reg;
    logic                 end_reg;

    // forwarded entry for a same-position follow-up
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [ENTRY_W-1:0]   fwd_entry_reg;

    logic                 primed_reg;
    logic [FCOUNT_W-1:0]  frame_count_reg, frame_count_next;
    logic [LEVEL_W-1:0]   lowest_reg, lowest_next;
    logic [LEVEL_W-1:0]   repl_thresh_reg;
    logic [LEVEL_W-1:0]   era_thresh_reg;

    // halving sweep
    logic [CW-1:0]        sweep_cnt_reg;
    logic                 sweep_pend_reg;
    logic [AW-1:0]        sweep_addr_reg;

    // result register
    logic                 m_tvalid_reg;
    logic [BYTE_W-1:0]    m_byte_reg;
    logic                 m_erased_reg;
    logic [LEVEL_W-1:0]   m_lowest_reg;

    // ------------------------------------------------------------------
    // combinational
    // ------------------------------------------------------------------
    logic [POS_W-1:0]     s_pos;
    logic [ENTRY_W-1:0]   rd_data;
    logic [ENTRY_W-1:0]   entry;
    logic [BYTE_W-1:0]    ent_byte;
    logic [COUNT_W-1:0]   ent_cnt;
    logic [LEVEL_W-1:0]   cnt_ext;
    logic [BYTE_W-1:0]    sym_byte;
    logic                 sym_big;
    logic                 in_range;
    logic                 out_free;
    logic                 exec_done;
    logic                 is_update;
    logic                 is_query;
    logic                 is_clear;
    logic [FCOUNT_W:0]    fc_inc;
    logic                 halve_hit;
    logic                 halve_start;
    logic                 accept;
    logic                 sweep_rd;
    logic [COUNT_W-1:0]   upd_cnt;
    logic                 exec_wr;
    logic [ENTRY_W-1:0]   exec_wr_data;
    logic [BYTE_W-1:0]    q_byte;
    logic                 q_erased;

    logic                 ram_we;
    logic [AW-1:0]        ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;

    assign s_pos     = s_tdata[POS_W-1:0];
    assign entry     = fwd_valid_reg ? fwd_entry_reg : rd_data;
    assign ent_byte  = entry[ENTRY_W-1 -: BYTE_W];
    assign ent_cnt   = entry[COUNT_W-1:0];
    assign cnt_ext   = {1'b0, ent_cnt};
    assign sym_byte  = sym_reg[BYTE_W-1:0];
    assign sym_big   = |sym_reg[SYM_W-1:BYTE_W];
    assign in_range  = {1'b0, pos_reg} < POS_LIMIT;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_done = (state_reg == ST_EXEC) && out_free;
    assign is_update = mode_reg == MODE_UPDATE;
    assign is_query  = mode_reg == MODE_QUERY;
    assign is_clear  = mode_reg == MODE_CLEAR;
    assign fc_inc    = {1'b0, frame_count_reg} + (FCOUNT_W + 1)'(1);
    assign halve_hit = fc_inc >= HALVE_LIMIT;
    assign sweep_rd  = sweep_cnt_reg < SWEEP_LIMIT;

    // a primed frame close that brings the frame counter to HALVE_AT starts the halving sweep
    assign halve_start = exec_done && is_update && end_reg && primed_reg && halve_hit;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (halve_start) begin
                    state_next = ST_HALVE;
                end else if (exec_done && !accept) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HALVE: begin
                if (!sweep_rd) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready = (state_reg == ST_IDLE) || (exec_done && !halve_start);
        accept   = s_tvalid && s_tready;

        // update: prime, or count a change (saturating)
        upd_cnt      = (ent_cnt == COUNT_MAX) ? ent_cnt : ent_cnt + COUNT_W'(1);
        exec_wr      = exec_done && is_update && in_range &&
                       (!primed_reg || (ent_byte != sym_byte));
        exec_wr_data = primed_reg ? {sym_byte, upd_cnt} : {sym_byte, {COUNT_W{1'b0}}};

        // query
        q_byte      = '0;
        q_erased    = 1'b0;
        lowest_next = lowest_reg;
        if (is_query) begin
            if (!in_range) begin
                q_erased = sym_big;
                q_byte   = sym_big ? '0 : sym_byte;
            end else begin
                if ((cnt_ext > era_thresh_reg) && (cnt_ext < lowest_reg)) begin
                    lowest_next = cnt_ext;
                end
                priority if (cnt_ext < repl_thresh_reg) begin
                    q_byte = ent_byte;
                end else if (cnt_ext < era_thresh_reg) begin
                    if (sym_reg == {{(SYM_W - BYTE_W){1'b0}}, ent_byte}) begin
                        q_byte = sym_byte;
                    end else begin
                        q_erased = 1'b1;
                    end
                end else begin
                    q_erased = sym_big;
                    q_byte   = sym_big ? '0 : sym_byte;
                end
            end
        end else if (is_clear) begin
            lowest_next = LEVEL_ALL_ONES;
        end

        // frame counter
        frame_count_next = frame_count_reg;
        if (is_update && end_reg) begin
            if (!primed_reg) begin
                frame_count_next = '0;
            end else if (halve_hit) begin
                frame_count_next = FCOUNT_W'(fc_inc >> 1);
            end else begin
                frame_count_next = fc_inc[FCOUNT_W-1:0];
            end
        end

        // RAM ports: sweep owns the RAM while halving
        if (state_reg == ST_HALVE) begin
            ram_we      = sweep_pend_reg;
            ram_wr_addr = sweep_addr_reg;
            ram_wr_data = {rd_data[ENTRY_W-1 -: BYTE_W], rd_data[COUNT_W-1:0] >> 1};
            ram_rd_addr = sweep_cnt_reg[AW-1:0];
        end else begin
            ram_we      = exec_wr;
            ram_wr_addr = pos_reg[AW-1:0];
            ram_wr_data = exec_wr_data;
            ram_rd_addr = accept ? s_pos[AW-1:0] : pos_reg[AW-1:0];
        end

        // RAM returns the old entry when the next item reads what we write now
        fwd_valid_next = exec_wr && (s_pos[AW-1:0] == pos_reg[AW-1:0]);
    end

    bseg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            fwd_valid_reg     <= 1'b0;
            primed_reg        <= 1'b0;
            frame_count_reg   <= '0;
            lowest_reg        <= LEVEL_ALL_ONES;
            repl_thresh_reg   <= '0;
            era_thresh_reg    <= '0;
            sweep_pend_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_REPL_THRESH: repl_thresh_reg <= cfg_wdata;
                    REG_ERA_THRESH:  era_thresh_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            if (accept) begin
                fwd_valid_reg <= fwd_valid_next;
            end

            if (exec_done) begin
                lowest_reg      <= lowest_next;
                frame_count_reg <= frame_count_next;
                if (is_update && end_reg) begin
                    primed_reg <= 1'b1;
                end
            end

            if (halve_start) begin
                sweep_pend_reg <= 1'b0;
            end else if (state_reg == ST_HALVE) begin
                sweep_pend_reg <= sweep_rd;
            end

            if (exec_done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg      <= s_tuser;
            pos_reg       <= s_pos;
            sym_reg       <= s_tdata[POS_W +: SYM_W];
            end_reg       <= s_tlast;
            fwd_entry_reg <= exec_wr_data;
        end

        if (halve_start) begin
            sweep_cnt_reg <= '0;
        end else if ((state_reg == ST_HALVE) && sweep_rd) begin
            sweep_cnt_reg  <= sweep_cnt_reg + CW'(1);
            sweep_addr_reg <= sweep_cnt_reg[AW-1:0];
        end

        if (exec_done) begin
            m_byte_reg   <= q_byte;
            m_erased_reg <= q_erased;
            m_lowest_reg <= lowest_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_erased_reg;
    assign m_tdata  = {{(M_TDATA_W - LEVEL_W - BYTE_W){1'b0}}, m_lowest_reg, m_byte_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BSEG_ASSERT_NEXT(a_halve_entry, halve_start, (state_reg == ST_HALVE) && !s_tready,
        "frame counter wrap did not start the halving sweep")
    `BSEG_ASSERT_NEXT(a_result_loaded, exec_done, m_tvalid_reg,
        "retired transaction left no result")
    `BSEG_ASSERT(a_wr_in_range, (ram_we |-> ({1'b0, ram_wr_addr} < (AW + 1)'(FRAME_LEN))),
        "store write beyond frame length")
    `BSEG_ASSERT(a_fcount_bound, ({1'b0, frame_count_reg} < HALVE_LIMIT),
        "frame counter reached the halving threshold")

endmodule

`default_nettype wire

// File: src/bseg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bseg_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
